// ----- src/dft_pkg.sv -----
// Package for the delimited field tokenizer: shared types, codes and reset values.
// No dependencies; every other file of the block imports it.
`default_nettype none

package dft_pkg;

   localparam int MAX_DELIM_LEN_DEFAULT = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DELIM_BYTES  = 3'd0,
      CSR_DELIM_LEN    = 3'd1,
      CSR_ANY_OF       = 3'd2,
      CSR_STOP_DOUBLE  = 3'd3,
      CSR_QUAL_EN      = 3'd4,
      CSR_OPEN_QUAL    = 3'd5,
      CSR_CLOSE_QUAL   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_BYTE         = 2'd0,
      CMD_BYTE_END     = 2'd1,
      CMD_EMPTY_STRING = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_BYTE      = 2'd0,
      KIND_TOKEN_END = 2'd1,
      KIND_DONE      = 2'd2,
      KIND_NO_CLOSE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DECIDE,
      PH_FLUSH,
      PH_TAIL
   } phase_type;

   typedef struct packed {
      logic [31:0] delim_bytes;
      logic [2:0]  delim_len;
      logic        any_of;
      logic        stop_double;
      logic        qual_en;
      logic [7:0]  open_qual;
      logic [7:0]  close_qual;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      delim_bytes: 32'd44,
      delim_len:   3'd1,
      any_of:      1'b0,
      stop_double: 1'b0,
      qual_en:     1'b0,
      open_qual:   8'd34,
      close_qual:  8'd34
   };

   typedef struct packed {
      cmd_type    op;
      logic [7:0] data;
   } q_entry_type;

endpackage

`default_nettype wire

// ----- src/dft_front.sv -----
// Front end of the tokenizer: input handshake and command classification.
// Depends on dft_pkg; feeds dft_queue.
`default_nettype none

module dft_front
   import dft_pkg::*;
(
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] command
   input  wire logic        q_full,
   output logic             q_push,
   output q_entry_type      q_entry
);

   logic known_cmd;

   assign req_tready = !q_full;

   // Drop the reserved command here: it has no effect on the string state.
   always_comb begin
      case (req_tuser)
         CMD_BYTE, CMD_BYTE_END, CMD_EMPTY_STRING: known_cmd = 1'b1;
         default: known_cmd = 1'b0;
      endcase
   end

   assign q_push = req_tvalid && req_tready && known_cmd;
   assign q_entry.op = cmd_type'(req_tuser);
   assign q_entry.data = req_tdata;

endmodule

`default_nettype wire

// ----- src/dft_queue.sv -----
// Short FIFO between the tokenizer front end and its sequencer.
// Depends on dft_pkg for the entry type.
`default_nettype none

module dft_queue
   import dft_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire q_entry_type push_entry,
   output logic             full,
   output logic             pop_valid,
   input  wire logic        pop,
   output q_entry_type      pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   q_entry_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- src/dft_back.sv -----
// Back end: lookahead window, one decision per cycle when not stalled, result staging.
// Depends on dft_pkg; takes items from dft_queue and drives the result channel.
`default_nettype none

module dft_back
   import dft_pkg::*;
#(
   parameter int MAX_DELIM_LEN = MAX_DELIM_LEN_DEFAULT
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        q_valid,
   input  wire q_entry_type q_entry,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   localparam int LEN_CAP = (MAX_DELIM_LEN < 4) ? MAX_DELIM_LEN : 4;
   localparam int CNT_W   = $clog2(MAX_DELIM_LEN + 1);

   // string state
   logic [7:0]       win_ff [MAX_DELIM_LEN];
   logic [7:0]       win_in [MAX_DELIM_LEN];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             quote_ff, quote_in;
   logic             stop_ff, stop_in;
   logic             jd_ff, jd_in;
   phase_type        phase_ff, phase_in;
   cmd_type          op_ff, op_in;

   // one-deep holding slot so the last flag is known before a result leaves
   logic             pend_v_ff, pend_v_in;
   logic             pend_fin_ff, pend_fin_in;
   kind_type         pend_kind_ff, pend_kind_in;
   logic [7:0]       pend_byte_ff, pend_byte_in;

   logic             out_v_ff, out_v_in;
   kind_type         out_kind_ff, out_kind_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;

   logic [3:0]       len_raw;
   logic [CNT_W-1:0] len, depth;
   logic             start, load, out_free, step, may_delim;
   cmd_type          op_now;
   logic [7:0]       ww [MAX_DELIM_LEN];
   logic [CNT_W-1:0] wc;
   logic             any_hit, seq_hit, delim_hit, full_cond, dec_go;

   logic [7:0]       dw [MAX_DELIM_LEN];
   logic [CNT_W-1:0] dc, drop_n;
   logic             dq, ds, dj, drop, more;
   logic             d_res_v;
   kind_type         d_kind;
   logic [7:0]       d_byte;

   logic             res_v, fin, clear, push_out;
   kind_type         res_kind;
   logic [7:0]       res_byte;

   // effective delimiter length and window depth
   always_comb begin
      len_raw = (cfg.delim_len == '0) ? 4'd1 : {1'b0, cfg.delim_len};
      if (len_raw > 4'(LEN_CAP)) begin
         len_raw = 4'(LEN_CAP);
      end
      len   = CNT_W'(len_raw);
      depth = cfg.any_of ? CNT_W'(1) : len;
   end

   assign start     = (phase_ff == PH_IDLE);
   assign op_now    = start ? q_entry.op : op_ff;
   assign load      = start && (op_now != CMD_EMPTY_STRING) && !stop_ff;
   assign out_free  = !out_v_ff || rsp_tready;
   assign step      = out_free && (!start || q_valid);
   assign q_pop     = out_free && start && q_valid;
   assign may_delim = (phase_ff != PH_FLUSH);

   // working window: append the incoming byte when an item starts
   always_comb begin
      for (int i = 0; i < MAX_DELIM_LEN; i++) begin
         ww[i] = win_ff[i];
         if (load && cnt_ff == CNT_W'(i)) begin
            ww[i] = q_entry.data;
         end
      end
      wc = load ? cnt_ff + 1'b1 : cnt_ff;
   end

   // delimiter match at the front of the window
   always_comb begin
      any_hit = 1'b0;
      seq_hit = (wc >= len);
      for (int i = 0; i < LEN_CAP; i++) begin
         if (CNT_W'(i) < len) begin
            if (ww[0] == cfg.delim_bytes[8*i +: 8]) begin
               any_hit = 1'b1;
            end
            if (ww[i] != cfg.delim_bytes[8*i +: 8]) begin
               seq_hit = 1'b0;
            end
         end
      end
      delim_hit = (wc != '0) && (cfg.any_of ? any_hit : seq_hit);
   end

   assign full_cond = !stop_ff && (wc != '0) && (wc >= depth);

   always_comb begin
      case (phase_ff)
         PH_IDLE:   dec_go = (op_now != CMD_EMPTY_STRING) && full_cond;
         PH_DECIDE: dec_go = full_cond;
         PH_FLUSH:  dec_go = !stop_ff && (wc != '0);
         default:   dec_go = 1'b0;
      endcase
   end

   // one decision on the oldest window position
   always_comb begin
      dw      = ww;
      dc      = wc;
      dq      = quote_ff;
      ds      = stop_ff;
      dj      = jd_ff;
      d_res_v = 1'b0;
      d_kind  = KIND_BYTE;
      d_byte  = ww[0];
      drop    = 1'b0;
      drop_n  = CNT_W'(1);
      if (dec_go) begin
         if (quote_ff) begin
            drop = 1'b1;
            dj   = 1'b0;
            if (ww[0] == cfg.close_qual) begin
               dq = 1'b0;
            end else begin
               d_res_v = 1'b1;
            end
         end else if (may_delim && delim_hit) begin
            if (jd_ff && cfg.stop_double) begin
               ds = 1'b1;
               dc = '0;
            end else begin
               d_res_v = 1'b1;
               d_kind  = KIND_TOKEN_END;
               d_byte  = '0;
               drop    = 1'b1;
               drop_n  = depth;
               dj      = 1'b1;
            end
         end else begin
            drop = 1'b1;
            dj   = 1'b0;
            if (cfg.qual_en && ww[0] == cfg.open_qual) begin
               dq = 1'b1;
            end else begin
               d_res_v = 1'b1;
            end
         end
      end
      if (drop) begin
         if (drop_n >= wc) begin
            dc = '0;
         end else begin
            dc = wc - drop_n;
            for (int k = 1; k < MAX_DELIM_LEN; k++) begin
               for (int i = 0; i + k < MAX_DELIM_LEN; i++) begin
                  if (drop_n == CNT_W'(k)) begin
                     dw[i] = ww[i + k];
                  end
               end
            end
         end
      end
      more = !ds && (dc != '0) && (dc >= depth);
   end

   // sequencer outputs: state update and result of this step
   always_comb begin
      win_in   = dw;
      cnt_in   = dc;
      quote_in = dq;
      stop_in  = ds;
      jd_in    = dj;
      op_in    = op_now;
      res_v    = d_res_v;
      res_kind = d_kind;
      res_byte = d_byte;
      fin      = 1'b0;
      clear    = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (op_now == CMD_EMPTY_STRING) begin
               res_v    = 1'b1;
               res_kind = KIND_DONE;
               res_byte = '0;
               clear    = 1'b1;
               fin      = 1'b1;
            end else begin
               fin = (op_now == CMD_BYTE) && !more;
            end
         end
         PH_DECIDE: begin
            fin = (op_now == CMD_BYTE) && !more;
         end
         PH_FLUSH: begin
            if (!dec_go) begin
               res_v    = 1'b1;
               res_byte = '0;
               clear    = 1'b1;
               if (stop_ff) begin
                  res_kind = KIND_DONE;
                  fin      = 1'b1;
               end else if (quote_ff) begin
                  res_kind = KIND_NO_CLOSE;
                  fin      = 1'b1;
               end else begin
                  res_kind = KIND_TOKEN_END;
               end
            end
         end
         PH_TAIL: begin
            res_v    = 1'b1;
            res_kind = KIND_DONE;
            res_byte = '0;
            clear    = 1'b1;
            fin      = 1'b1;
         end
         default: begin
            fin = 1'b1;
         end
      endcase
      if (clear) begin
         cnt_in   = '0;
         quote_in = 1'b0;
         stop_in  = 1'b0;
         jd_in    = 1'b0;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (q_valid && op_now != CMD_EMPTY_STRING) begin
               if (more) begin
                  phase_in = PH_DECIDE;
               end else if (op_now == CMD_BYTE_END) begin
                  phase_in = PH_FLUSH;
               end
            end
         end
         PH_DECIDE: begin
            if (more) begin
               phase_in = PH_DECIDE;
            end else if (op_now == CMD_BYTE_END) begin
               phase_in = PH_FLUSH;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_FLUSH: begin
            if (!dec_go) begin
               phase_in = (stop_ff || quote_ff) ? PH_IDLE : PH_TAIL;
            end
         end
         PH_TAIL: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // result staging: release the held result once the next one or the item end is seen,
   // and only into a free output register
   always_comb begin
      push_out     = pend_v_ff && out_free && (pend_fin_ff || (step && (res_v || fin)));
      pend_v_in    = pend_v_ff;
      pend_fin_in  = pend_fin_ff;
      pend_kind_in = pend_kind_ff;
      pend_byte_in = pend_byte_ff;
      if (step && res_v) begin
         pend_v_in    = 1'b1;
         pend_fin_in  = fin;
         pend_kind_in = res_kind;
         pend_byte_in = res_byte;
      end else if (push_out) begin
         pend_v_in = 1'b0;
      end
      out_v_in    = out_v_ff;
      out_kind_in = out_kind_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      if (push_out) begin
         out_v_in    = 1'b1;
         out_kind_in = pend_kind_ff;
         out_byte_in = pend_byte_ff;
         out_last_in = pend_fin_ff || (step && fin && !res_v);
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         cnt_ff      <= '0;
         quote_ff    <= 1'b0;
         stop_ff     <= 1'b0;
         jd_ff       <= 1'b0;
         pend_v_ff   <= 1'b0;
         pend_fin_ff <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
            quote_ff <= quote_in;
            stop_ff  <= stop_in;
            jd_ff    <= jd_in;
         end
         pend_v_ff   <= pend_v_in;
         pend_fin_ff <= pend_fin_in;
         out_v_ff    <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         win_ff <= win_in;
         op_ff  <= op_in;
      end
      pend_kind_ff <= pend_kind_in;
      pend_byte_ff <= pend_byte_in;
      out_kind_ff  <= out_kind_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ----- src/delimited_field_tokenizer.sv -----
// Path: results pass the holding slot and the output register; a plain byte with a full
//   window is decided in the step that pops it from the queue.
// Throughput: one byte per cycle while the queue has room; one window decision per cycle
//   while the output is free; an end byte adds flush decisions and the string end results.
// Reset: synchronous, active high; clears the queue, sequencer and output stage, and loads
//   the default configuration (comma delimiter, length one, double-quote qualifiers off).
`default_nettype none

module delimited_field_tokenizer
   import dft_pkg::*;
#(
   parameter int MAX_DELIM_LEN = MAX_DELIM_LEN_DEFAULT
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // byte stream in
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] in_byte
   input  wire logic [1:0]             req_tuser,   // [1:0] command
   // token stream out
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]                  rsp_tuser,   // [1:0] kind
   output logic                        rsp_tlast,   // last result of this input transfer
   // register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        q_push, q_full, q_valid, q_pop;
   q_entry_type q_push_entry, q_pop_entry;

   // Register writes are always accepted.
   assign csr_ready = 1'b1;

   // Decode the write; an index past the register list is taken and ignored.
   always_comb begin
      cfg_in = cfg_ff;
      case (csr_index)
         CSR_DELIM_BYTES: cfg_in.delim_bytes = csr_data[31:0];
         CSR_DELIM_LEN:   cfg_in.delim_len   = csr_data[2:0];
         CSR_ANY_OF:      cfg_in.any_of      = csr_data[0];
         CSR_STOP_DOUBLE: cfg_in.stop_double = csr_data[0];
         CSR_QUAL_EN:     cfg_in.qual_en     = csr_data[0];
         CSR_OPEN_QUAL:   cfg_in.open_qual   = csr_data[7:0];
         CSR_CLOSE_QUAL:  cfg_in.close_qual  = csr_data[7:0];
         default:         cfg_in = cfg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: take the transfer and classify the command.
   dft_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_push_entry)
   );

   // Queue decouples input stalls from the window sequencer.
   dft_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry)
   );

   // Back end: window, quote and stop tracking, result staging and output register.
   dft_back #(
      .MAX_DELIM_LEN (MAX_DELIM_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_entry    (q_pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- src/dft_checker.sv -----
// Port-level checks for the tokenizer, attached to the top level by a bind.
// Depends on dft_pkg for the result kind codes.
`default_nettype none

module dft_checker
   import dft_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser,
   input wire logic       rsp_tlast
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Only token bytes carry data.
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_BYTE |-> rsp_tdata == 8'd0)
      else $error("non-byte result with nonzero data");

   // String done and missing close qualifier always end a transfer's results.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_DONE || rsp_tuser == KIND_NO_CLOSE) |-> rsp_tlast)
      else $error("string end result without last");

   // No result right out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind delimited_field_tokenizer dft_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ----- dv/delimited_field_tokenizer_tb.sv -----
// Self-checking bench for delimited_field_tokenizer: directed strings, then random records
// under four handshake mixes, each result checked against an in-bench token predictor.
// Depends on dft_pkg (codes, register indexes, reset configuration) and the RTL top level.
`timescale 1ns / 100ps

module delimited_field_tokenizer_tb;
   import dft_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;   // command code the block must ignore
   localparam int MAX_RESULTS = 7;             // bound on the results one transfer can cause
   localparam int SETTLE_CYCLES = 16;          // covers an end-of-string flush of a full window
   localparam int ITEMS_PER_PHASE = 47;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } token_result_type;

   // Predicts the token stream and holds the results still owed by the block.
   class token_scoreboard;
      logic [31:0] delim_bytes;
      logic [2:0]  delim_len_reg;
      bit          any_of;
      bit          stop_double;
      bit          qual_en;
      logic [7:0]  open_qual;
      logic [7:0]  close_qual;

      logic [7:0]  window [4];
      int unsigned fill;
      bit          in_quote;
      bit          stopped;
      bit          just_delimited;

      token_result_type pending_tokens[$];
      token_result_type step_tokens[$];
      int errors;
      int checked;

      function new();
         delim_bytes   = CFG_RESET.delim_bytes;
         delim_len_reg = CFG_RESET.delim_len;
         any_of        = CFG_RESET.any_of;
         stop_double   = CFG_RESET.stop_double;
         qual_en       = CFG_RESET.qual_en;
         open_qual     = CFG_RESET.open_qual;
         close_qual    = CFG_RESET.close_qual;
         errors        = 0;
         checked       = 0;
         clear_string();
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] val);
         case (idx)
            CSR_DELIM_BYTES: delim_bytes = val;
            CSR_DELIM_LEN:   delim_len_reg = val[2:0];
            CSR_ANY_OF:      any_of = val[0];
            CSR_STOP_DOUBLE: stop_double = val[0];
            CSR_QUAL_EN:     qual_en = val[0];
            CSR_OPEN_QUAL:   open_qual = val[7:0];
            CSR_CLOSE_QUAL:  close_qual = val[7:0];
            default: ;
         endcase
      endfunction

      // Length zero acts as one; anything above the byte count saturates.
      function int unsigned match_len();
         int unsigned n;
         int unsigned cap;
         cap = (MAX_DELIM_LEN_DEFAULT < 4) ? MAX_DELIM_LEN_DEFAULT : 4;
         n = delim_len_reg;
         if (n < 1) n = 1;
         if (n > cap) n = cap;
         return n;
      endfunction

      function int unsigned window_depth();
         return any_of ? 1 : match_len();
      endfunction

      function logic [7:0] delim_byte(int unsigned i);
         return delim_bytes[8*(i % 4) +: 8];
      endfunction

      function void shift_out(int unsigned n);
         if (n >= fill) begin
            fill = 0;
         end else begin
            for (int unsigned i = 0; i < fill - n; i++) window[i] = window[i + n];
            fill = fill - n;
         end
      endfunction

      function bit delim_at_head();
         int unsigned len;
         len = match_len();
         if (fill == 0) return 1'b0;
         if (any_of) begin
            for (int unsigned i = 0; i < len; i++)
               if (window[0] == delim_byte(i)) return 1'b1;
            return 1'b0;
         end
         if (fill < len) return 1'b0;
         for (int unsigned i = 0; i < len; i++)
            if (window[i] != delim_byte(i)) return 1'b0;
         return 1'b1;
      endfunction

      function void push_token(kind_type k, logic [7:0] b);
         token_result_type t;
         if (step_tokens.size() >= MAX_RESULTS) return;
         t.kind = k;
         t.data = (k == KIND_BYTE) ? b : 8'h00;
         t.last = 1'b0;
         step_tokens = {step_tokens, t};
      endfunction

      // Decide the oldest window byte: quoted run first, then delimiter, then qualifier.
      function void decide_head(bit may_delimit);
         logic [7:0] b;
         b = window[0];
         if (in_quote) begin
            shift_out(1);
            just_delimited = 1'b0;
            if (b == close_qual) in_quote = 1'b0;
            else push_token(KIND_BYTE, b);
         end else if (may_delimit && delim_at_head()) begin
            if (just_delimited && stop_double) begin
               stopped = 1'b1;
               fill = 0;
            end else begin
               push_token(KIND_TOKEN_END, 8'h00);
               shift_out(window_depth());
               just_delimited = 1'b1;
            end
         end else begin
            shift_out(1);
            just_delimited = 1'b0;
            if (qual_en && b == open_qual) in_quote = 1'b1;
            else push_token(KIND_BYTE, b);
         end
      endfunction

      function void clear_string();
         foreach (window[i]) window[i] = 8'h00;
         fill = 0;
         in_quote = 1'b0;
         stopped = 1'b0;
         just_delimited = 1'b0;
      endfunction

      // Note an accepted input transfer and queue the results it causes.
      function void note_input(logic [1:0] cmd, logic [7:0] b);
         step_tokens.delete();
         if (cmd == CMD_EMPTY_STRING) begin
            clear_string();
            push_token(KIND_DONE, 8'h00);
         end else if (cmd == CMD_BYTE || cmd == CMD_BYTE_END) begin
            if (!stopped) begin
               if (fill >= MAX_DELIM_LEN_DEFAULT) shift_out(1);
               window[fill] = b;
               fill++;
               while (!stopped && fill > 0 && fill >= window_depth()) decide_head(1'b1);
            end
            if (cmd == CMD_BYTE_END) begin
               // flush what is left: too few bytes to hold a delimiter
               while (!stopped && fill > 0) decide_head(1'b0);
               if (stopped) begin
                  push_token(KIND_DONE, 8'h00);
               end else if (in_quote) begin
                  push_token(KIND_NO_CLOSE, 8'h00);
               end else begin
                  push_token(KIND_TOKEN_END, 8'h00);
                  push_token(KIND_DONE, 8'h00);
               end
               clear_string();
            end
         end
         if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
         pending_tokens = {pending_tokens, step_tokens};
      endfunction

      function void check_token(kind_type k, logic [7:0] b, logic last);
         token_result_type want;
         if (pending_tokens.size() == 0) begin
            $error("unexpected result: kind %0d, out_byte %0h, last %0b", k, b, last);
            errors++;
            return;
         end
         want = pending_tokens.pop_front();
         checked++;
         if (k !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, k);
            errors++;
         end
         if (b !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, b);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [7:0] in_byte
   logic [1:0]             req_tuser;   // [1:0] command
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;   // [7:0] out_byte
   logic [1:0]             rsp_tuser;   // [1:0] kind
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   token_scoreboard sb = new();

   int sender_idle_pct = 0;   // chance per cycle that the sender holds off
   int stall_pct = 0;         // chance per cycle that the receiver stalls
   int items_sent = 0;        // transfers the block acts on; unused commands excluded
   int strings_sent = 0;
   int settings_used = 1;

   delimited_field_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run of all phases.
   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Receiver: pick ready for the coming edge at each falling edge.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= stall_pct);
      end
   end

   // Check every result transfer against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_token(kind_type'(rsp_tuser), rsp_tdata, rsp_tlast);
   end

   // Present one input item and hold it until the transfer; called and returns at a falling edge.
   // Leave tvalid high afterwards so back-to-back items never drop it for a step.
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = b;
      do @(posedge clock); while (!req_tready);
      sb.note_input(cmd, b);
      if (cmd != CMD_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   // Drop valid, wait until every owed result has come, then let the back end go quiet.
   task automatic settle();
      req_tvalid = 1'b0;
      while (sb.pending_tokens.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one register; the stream must be settled first.
   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_setting(input logic [31:0] bytes_val, input logic [2:0] len,
                               input bit any, input bit stop, input bit qen,
                               input logic [7:0] open_b, input logic [7:0] close_b);
      settle();
      write_reg(CSR_DELIM_BYTES, bytes_val);
      write_reg(CSR_DELIM_LEN, {29'd0, len});
      write_reg(CSR_ANY_OF, {31'd0, any});
      write_reg(CSR_STOP_DOUBLE, {31'd0, stop});
      write_reg(CSR_QUAL_EN, {31'd0, qen});
      write_reg(CSR_OPEN_QUAL, {24'd0, open_b});
      write_reg(CSR_CLOSE_QUAL, {24'd0, close_b});
      settings_used++;
   endtask

   // Field content: lean on delimiter and qualifier bytes so matches and quoted runs are common.
   function automatic logic [7:0] field_byte();
      case ($urandom_range(9))
         0, 1:    return sb.delim_byte($urandom_range(3));
         2:       return sb.open_qual;
         3:       return sb.close_qual;
         4:       return 8'($urandom_range(255));
         default: return 8'h61 + 8'($urandom_range(25));   // lowercase letter
      endcase
   endfunction

   // One well-formed string: fields with whole delimiters between, closed by an end byte.
   task automatic send_record();
      int pieces;
      int unsigned len;
      pieces = $urandom_range(10);
      for (int p = 0; p < pieces; p++) begin
         if ($urandom_range(4) == 0) begin
            len = sb.match_len();
            for (int unsigned k = 0; k < len; k++) send_item(CMD_BYTE, sb.delim_byte(k));
         end else begin
            send_item(CMD_BYTE, field_byte());
         end
      end
      send_item(CMD_BYTE_END, field_byte());
      strings_sent++;
   endtask

   // Noise: random commands and bytes, including aborts and the unused code.
   task automatic send_noise();
      int n;
      logic [1:0] cmd;
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0:       cmd = CMD_UNUSED;
            1:       cmd = CMD_EMPTY_STRING;
            2:       cmd = CMD_BYTE_END;
            default: cmd = CMD_BYTE;
         endcase
         send_item(cmd, 8'($urandom_range(255)));
      end
   endtask

   task automatic run_random(input int goal);
      while (items_sent < goal) begin
         if ($urandom_range(9) < 8) send_record();
         else send_noise();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = CMD_BYTE;
      csr_valid  = 1'b0;
      csr_index  = CSR_DELIM_BYTES;
      csr_data   = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Directed strings under the reset configuration, no idling.
      send_item(CMD_EMPTY_STRING, 8'hA5);            // byte ignored, only string done
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_BYTE, 8'hFF);
      send_item(CMD_BYTE, ",");
      send_item(CMD_BYTE_END, ",");                  // two delimiters, empty tokens allowed
      send_item(CMD_BYTE, "x");
      send_item(CMD_UNUSED, ",");                    // ignored mid-string
      send_item(CMD_BYTE_END, "y");
      send_item(CMD_BYTE, "q");
      send_item(CMD_EMPTY_STRING, 8'h00);            // abort a string in flight

      settle();
      write_reg(CSR_QUAL_EN, 32'd1);
      write_reg(CSR_STOP_DOUBLE, 32'd1);
      send_item(CMD_BYTE, "\"");                     // quoted delimiter passes through
      send_item(CMD_BYTE, ",");
      send_item(CMD_BYTE, "\"");
      send_item(CMD_BYTE_END, "z");
      send_item(CMD_BYTE, "\"");                     // run never closed
      send_item(CMD_BYTE_END, "a");
      send_item(CMD_BYTE, "a");                      // double delimiter drops the rest
      send_item(CMD_BYTE, ",");
      send_item(CMD_BYTE, ",");
      send_item(CMD_BYTE, "b");
      send_item(CMD_BYTE_END, "c");

      // Same byte as delimiter and open qualifier: the delimiter must win.
      settle();
      write_reg(CSR_OPEN_QUAL, 32'h2C);
      send_item(CMD_BYTE_END, ",");

      // Open a run, then turn qualifiers off: the close byte still ends it.
      settle();
      write_reg(CSR_OPEN_QUAL, 32'h22);
      send_item(CMD_BYTE, "\"");
      settle();
      write_reg(CSR_QUAL_EN, 32'd0);
      send_item(CMD_BYTE_END, "\"");

      // Shrink the window depth while it holds bytes.
      settle();
      write_reg(CSR_DELIM_BYTES, 32'h0063_6261);
      write_reg(CSR_DELIM_LEN, 32'd3);
      send_item(CMD_BYTE, "a");
      send_item(CMD_BYTE, "b");
      settle();
      write_reg(CSR_DELIM_LEN, 32'd1);
      send_item(CMD_BYTE_END, "c");

      // Random phases: each with its own register setting and handshake mix.
      load_setting(32'hFF00_3A3A, 3'd2, 1'b0, 1'b1, 1'b1, 8'h28, 8'h29);
      sender_idle_pct = 0;
      stall_pct = 0;
      run_random(items_sent + ITEMS_PER_PHASE);

      load_setting(32'hFF00_7C3B, 3'd7, 1'b1, 1'b0, 1'b1, 8'h00, 8'hFF);
      sender_idle_pct = 72;
      stall_pct = 0;
      run_random(items_sent + ITEMS_PER_PHASE);

      load_setting(32'h0000_0000, 3'd3, 1'b0, 1'b1, 1'b0, 8'hFF, 8'h00);
      sender_idle_pct = 0;
      stall_pct = 72;
      run_random(items_sent + ITEMS_PER_PHASE);

      load_setting(32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 1'b1, 8'h27, 8'h27);
      sender_idle_pct = 27;
      stall_pct = 27;
      run_random(items_sent + ITEMS_PER_PHASE);

      settle();
      $display("Covered %0d input transfers (%0d random strings) over %0d register settings,",
               items_sent, strings_sent, settings_used);
      $display("four handshake mixes and %0d checked results.", sb.checked);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
